// ----- design/sphere_surface_projection_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SPHERE_SURFACE_PROJECTION_UNIT_MACROS_SVH
`define SPHERE_SURFACE_PROJECTION_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication with the consequent checked in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sphere projection package
// Shared constants, widths, register indexes and a saturating helper.
// ----------------------------------------------------------------------------
package ssp_pkg;
    localparam int CoordW = 32;
    localparam int RadW = 31;
    localparam int DiffW = 33;
    localparam int MagW = 31;
    localparam int SumW = 64;
    localparam int RootW = 32;
    localparam int ProdW = 62;
    localparam int QuotW = 32;
    localparam int ShW = 5;
    localparam logic [RadW-1:0] RadiusReset = 31'd32768;

    typedef enum logic [1:0] {
        REG_CX = 2'd0,
        REG_CY = 2'd1,
        REG_CZ = 2'd2,
        REG_R  = 2'd3
    } t_reg_idx;

    // Saturate a 34-bit signed sum to the 32-bit range.
    function automatic logic [CoordW-1:0] sat32(input logic signed [DiffW:0] v);
        logic [CoordW-1:0] res;
        if (v > 34'sh0_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = v[CoordW-1:0];
        end
        return res;
    endfunction
endpackage

// ----- design/ssp_norm.sv -----
// ----------------------------------------------------------------------------
// Sphere projection normalize stages
// Offset from centre, magnitudes and common power-of-two scaling.
// ----------------------------------------------------------------------------
module ssp_norm (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [ssp_pkg::CoordW-1:0]   i_px,
    input  logic signed [ssp_pkg::CoordW-1:0]   i_py,
    input  logic signed [ssp_pkg::CoordW-1:0]   i_pz,
    input  logic signed [ssp_pkg::CoordW-1:0]   i_cx,
    input  logic signed [ssp_pkg::CoordW-1:0]   i_cy,
    input  logic signed [ssp_pkg::CoordW-1:0]   i_cz,
    output logic [2:0]                          o_neg,
    output logic [ssp_pkg::MagW-1:0]            o_mx,
    output logic [ssp_pkg::MagW-1:0]            o_my,
    output logic [ssp_pkg::MagW-1:0]            o_mz,
    output logic                                o_zero
);
    logic [ssp_pkg::DiffW-1:0] r_ax, r_ay, r_az;
    logic [2:0]                r_neg1;
    logic signed [ssp_pkg::DiffW-1:0] dx, dy, dz;
    logic [ssp_pkg::DiffW-1:0] m;
    logic [ssp_pkg::ShW:0]     lz;
    logic [ssp_pkg::MagW-1:0]  n_mx, n_my, n_mz;

    assign dx = ssp_pkg::DiffW'(i_px) - ssp_pkg::DiffW'(i_cx);
    assign dy = ssp_pkg::DiffW'(i_py) - ssp_pkg::DiffW'(i_cy);
    assign dz = ssp_pkg::DiffW'(i_pz) - ssp_pkg::DiffW'(i_cz);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax <= dx[ssp_pkg::DiffW-1] ? -dx : dx;
            r_ay <= dy[ssp_pkg::DiffW-1] ? -dy : dy;
            r_az <= dz[ssp_pkg::DiffW-1] ? -dz : dz;
            r_neg1 <= {dz[ssp_pkg::DiffW-1], dy[ssp_pkg::DiffW-1], dx[ssp_pkg::DiffW-1]};
        end
    end

    // Position of the leading one in the OR of the magnitudes sets the shift.
    always_comb begin
        m = r_ax | r_ay | r_az;
        lz = '0;
        for (int i = 0; i < ssp_pkg::DiffW; i++) begin
            if (m[i]) lz = (ssp_pkg::ShW+1)'(i);
        end
        if (lz >= 6'd30) begin
            n_mx = ssp_pkg::MagW'(r_ax >> (lz - 6'd30));
            n_my = ssp_pkg::MagW'(r_ay >> (lz - 6'd30));
            n_mz = ssp_pkg::MagW'(r_az >> (lz - 6'd30));
        end else begin
            n_mx = ssp_pkg::MagW'(r_ax << (6'd30 - lz));
            n_my = ssp_pkg::MagW'(r_ay << (6'd30 - lz));
            n_mz = ssp_pkg::MagW'(r_az << (6'd30 - lz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mx <= n_mx;
            o_my <= n_my;
            o_mz <= n_mz;
            o_neg <= r_neg1;
            o_zero <= (m == '0);
        end
    end
endmodule

// ----- design/ssp_sqrt.sv -----
// ----------------------------------------------------------------------------
// Sphere projection square root
// Sum of squares and a pipelined restoring square root, one bit a stage.
// ----------------------------------------------------------------------------
module ssp_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ssp_pkg::MagW-1:0]       i_mx,
    input  logic [ssp_pkg::MagW-1:0]       i_my,
    input  logic [ssp_pkg::MagW-1:0]       i_mz,
    output logic [ssp_pkg::RootW-1:0]      o_root
);
    localparam int Steps = ssp_pkg::RootW;
    logic [ssp_pkg::ProdW-1:0] r_sx, r_sy, r_sz;
    logic [ssp_pkg::SumW-1:0]  r_rem [Steps+1];
    logic [ssp_pkg::RootW-1:0] r_q   [Steps+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= ssp_pkg::ProdW'(i_mx) * ssp_pkg::ProdW'(i_mx);
            r_sy <= ssp_pkg::ProdW'(i_my) * ssp_pkg::ProdW'(i_my);
            r_sz <= ssp_pkg::ProdW'(i_mz) * ssp_pkg::ProdW'(i_mz);
            r_rem[0] <= ssp_pkg::SumW'(r_sx) + ssp_pkg::SumW'(r_sy)
                        + ssp_pkg::SumW'(r_sz);
            r_q[0] <= '0;
        end
    end

    // Each stage decides one root bit, from the top.
    for (genvar k = 0; k < Steps; k++) begin : g_root
        localparam int B = Steps - 1 - k;
        logic [ssp_pkg::SumW+1:0] trial;
        always_comb begin
            trial = ({2'b0, r_rem[k]})
                    - (({34'b0, r_q[k]} << (B + 1)) | (66'd1 << (2 * B)));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!trial[ssp_pkg::SumW+1]) begin
                    r_rem[k+1] <= trial[ssp_pkg::SumW-1:0];
                    r_q[k+1] <= r_q[k] | (ssp_pkg::RootW'(1) << B);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1] <= r_q[k];
                end
            end
        end
    end

    assign o_root = r_q[Steps];
endmodule

// ----- design/ssp_div.sv -----
// ----------------------------------------------------------------------------
// Sphere projection divider
// Pipelined restoring division of the rounded product by the root.
// ----------------------------------------------------------------------------
module ssp_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [ssp_pkg::ProdW-1:0]      i_num,
    input  logic [ssp_pkg::RootW-1:0]      i_den,
    output logic [ssp_pkg::QuotW-1:0]      o_quot
);
    localparam int Steps = ssp_pkg::QuotW;
    logic [ssp_pkg::ProdW-1:0] r_rem [Steps+1];
    logic [ssp_pkg::RootW-1:0] r_den [Steps+1];
    logic [ssp_pkg::QuotW-1:0] r_q   [Steps+1];

    always_comb begin
        r_rem[0] = i_num;
        r_den[0] = i_den;
        r_q[0] = '0;
    end

    // Quotient stays below 2^32 since R < 2^31 and each magnitude <= root.
    for (genvar k = 0; k < Steps; k++) begin : g_div
        localparam int B = Steps - 1 - k;
        logic [ssp_pkg::ProdW+ssp_pkg::QuotW-1:0] sh;
        assign sh = {32'b0, r_den[k]} << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                if ({32'b0, r_rem[k]} >= sh) begin
                    r_rem[k+1] <= r_rem[k] - ssp_pkg::ProdW'(sh);
                    r_q[k+1] <= r_q[k] | (ssp_pkg::QuotW'(1) << B);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1] <= r_q[k];
                end
            end
        end
    end

    assign o_quot = r_q[Steps];
endmodule

// ----- design/sphere_surface_projection_unit.sv -----
// ----------------------------------------------------------------------------
// Sphere surface projection unit
// Moves each vertex radially onto the configured sphere, Q16.16.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one vertex per transfer, output stream m_axis
// one projected point; the at-centre flag travels on m_axis_tuser.
// Throughput is one vertex per cycle while the receiver keeps up. From an
// input transfer to the output register there are two normalize stages,
// one square stage, one sum stage, 32 square-root stages, one product
// stage, 32 divider stages and the output stage; the bit-per-stage root
// and divider set that depth.
// The whole pipeline advances as one; when the receiver stalls with a
// result waiting, every stage holds and s_axis_tready drops, so nothing is
// lost or repeated. Reset empties the pipeline and loads the registers:
// centre 0 and radius 0.5. The APB port writes the centre and radius; it
// must only be written while no vertex is in flight.
// ----------------------------------------------------------------------------
module sphere_surface_projection_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // proj_x [31:0], proj_y [63:32], proj_z [95:64]
    output logic [95:0]  m_axis_tdata,
    // at_centre [0]
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int Lat = 70;
    localparam int DivLat = 32;

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_rad;
    logic [Lat-1:0]     r_vld;
    logic               en;
    ssp_pkg::t_reg_idx  widx;

    assign pready = 1'b1;
    assign widx = ssp_pkg::t_reg_idx'(paddr[3:2]);
    assign en = !m_axis_tvalid || m_axis_tready || !r_vld[Lat-1];
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_rad <= ssp_pkg::RadiusReset;
        end else if (psel && penable && pwrite) begin
            case (widx)
                ssp_pkg::REG_CX: r_cx <= pwdata;
                ssp_pkg::REG_CY: r_cy <= pwdata;
                ssp_pkg::REG_CZ: r_cz <= pwdata;
                ssp_pkg::REG_R:  r_rad <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            ssp_pkg::REG_CX: prdata = r_cx;
            ssp_pkg::REG_CY: prdata = r_cy;
            ssp_pkg::REG_CZ: prdata = r_cz;
            ssp_pkg::REG_R:  prdata = {1'b0, r_rad};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[Lat-1];

    logic [2:0]  neg2;
    logic [30:0] mx, my, mz;
    logic        zero2;

    ssp_norm u_norm (
        .i_clk(i_clk), .i_en(en),
        .i_px(s_axis_tdata[31:0]), .i_py(s_axis_tdata[63:32]),
        .i_pz(s_axis_tdata[95:64]),
        .i_cx(r_cx), .i_cy(r_cy), .i_cz(r_cz),
        .o_neg(neg2), .o_mx(mx), .o_my(my), .o_mz(mz), .o_zero(zero2)
    );

    logic [31:0] root;
    ssp_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_mx(mx), .i_my(my), .i_mz(mz),
        .o_root(root)
    );

    // Side data delayed alongside the square and root pipeline (34 stages).
    logic [65:0] r_side [34];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= {zero2, neg2, mx, my};
            for (int i = 1; i < 34; i++) r_side[i] <= r_side[i-1];
        end
    end
    logic [30:0] r_mzh [34];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mzh[0] <= mz;
            for (int i = 1; i < 34; i++) r_mzh[i] <= r_mzh[i-1];
        end
    end

    // Product stage: radius times magnitude plus half the root.
    logic [61:0] r_nx, r_ny, r_nz;
    logic [31:0] r_den;
    logic [3:0]  r_fl;
    logic [30:0] sx, sy, sz;
    assign sx = r_side[33][61:31];
    assign sy = r_side[33][30:0];
    assign sz = r_mzh[33];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx <= 62'(r_rad) * 62'(sx) + 62'(root[31:1]);
            r_ny <= 62'(r_rad) * 62'(sy) + 62'(root[31:1]);
            r_nz <= 62'(r_rad) * 62'(sz) + 62'(root[31:1]);
            r_den <= (root == '0) ? 32'd1 : root;
            r_fl <= r_side[33][65:62];
        end
    end

    logic [31:0] qx, qy, qz;
    ssp_div u_dx (.i_clk(i_clk), .i_en(en), .i_num(r_nx), .i_den(r_den), .o_quot(qx));
    ssp_div u_dy (.i_clk(i_clk), .i_en(en), .i_num(r_ny), .i_den(r_den), .o_quot(qy));
    ssp_div u_dz (.i_clk(i_clk), .i_en(en), .i_num(r_nz), .i_den(r_den), .o_quot(qz));

    logic [3:0] r_fd [DivLat];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fd[0] <= r_fl;
            for (int i = 1; i < DivLat; i++) r_fd[i] <= r_fd[i-1];
        end
    end

    logic signed [33:0] ux, uy, uz, cz_pole;
    logic [3:0] fl;
    assign fl = r_fd[DivLat-1];
    assign ux = fl[0] ? -34'(qx) : 34'(qx);
    assign uy = fl[1] ? -34'(qy) : 34'(qy);
    assign uz = fl[2] ? -34'(qz) : 34'(qz);
    assign cz_pole = 34'(r_cz) + 34'(r_rad);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (fl[3]) begin
                m_axis_tdata <= {ssp_pkg::sat32(cz_pole), r_cy, r_cx};
            end else begin
                m_axis_tdata <= {ssp_pkg::sat32(34'(r_cz) + uz),
                                 ssp_pkg::sat32(34'(r_cy) + uy),
                                 ssp_pkg::sat32(34'(r_cx) + ux)};
            end
            m_axis_tuser <= fl[3];
        end
    end
endmodule

// ----- design/ssp_checker.sv -----
// ----------------------------------------------------------------------------
// Sphere projection port checker
// Watches the top-level ports for stream handshake rules and APB pready.
// ----------------------------------------------------------------------------
`include "sphere_surface_projection_unit_macros.svh"
module ssp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic         s_axis_tready,
    input logic         pready
);
    `SSP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SSP_ASSERT_IMP(a_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `SSP_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind sphere_surface_projection_unit ssp_checker u_ssp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .s_axis_tready(s_axis_tready), .pready(pready)
);

// ----- verif/sphere_surface_projection_unit_test.sv -----
// ----------------------------------------------------------------------------
// Sphere surface projection unit testbench
// Sends vertices through the stream port under several centre and radius
// settings, predicts each projected point in integer arithmetic and checks
// every output transfer field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module sphere_surface_projection_unit_test;
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        pole;
    } t_proj;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sphere_surface_projection_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the centre and radius registers.
    logic signed [31:0] cen_x = 0, cen_y = 0, cen_z = 0;
    logic [30:0]        radius = 31'd32768;

    t_proj projections[$];
    int    mismatches = 0;
    int    hold_cycles = 0;
    bit    stall_on = 1'b1;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_proj project_vertex(input logic [31:0] vx, input logic [31:0] vy,
                                             input logic [31:0] vz);
        t_proj       res;
        longint      cen[3];
        longint      d[3];
        logic [63:0] mag[3];
        logic [63:0] m, sum, n, q;
        longint      u;
        cen[0] = cen_x;
        cen[1] = cen_y;
        cen[2] = cen_z;
        d[0] = longint'($signed(vx)) - cen[0];
        d[1] = longint'($signed(vy)) - cen[1];
        d[2] = longint'($signed(vz)) - cen[2];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (d[i] < 0) ? -d[i] : d[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            res.px = cen_x;
            res.py = cen_y;
            res.pz = clamp32(cen[2] + longint'(radius));
            res.pole = 1'b1;
            return res;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        n = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (64'(radius) * mag[i] + (n >> 1)) / n;
            u = (d[i] < 0) ? -longint'(q) : longint'(q);
            d[i] = cen[i] + u;
        end
        res.px = clamp32(d[0]);
        res.py = clamp32(d[1]);
        res.pz = clamp32(d[2]);
        res.pole = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_on) begin
            m_axis_tready <= (random_gap() == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_proj want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (projections.size() == 0) begin
                report_mismatch("unexpected transfer proj_x", m_axis_tdata[31:0], 32'h0);
            end else begin
                want = projections.pop_front();
                if (m_axis_tdata[31:0] !== want.px)
                    report_mismatch("proj_x", m_axis_tdata[31:0], want.px);
                if (m_axis_tdata[63:32] !== want.py)
                    report_mismatch("proj_y", m_axis_tdata[63:32], want.py);
                if (m_axis_tdata[95:64] !== want.pz)
                    report_mismatch("proj_z", m_axis_tdata[95:64], want.pz);
                if (m_axis_tuser !== want.pole)
                    report_mismatch("at_centre", 32'(m_axis_tuser), 32'(want.pole));
            end
        end
    end

    task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                               input logic [31:0] vz, input bit gaps);
        int gap;
        gap = gaps ? random_gap() : 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vz, vy, vx};
        do @(posedge i_clk); while (!s_axis_tready);
        projections.push_back(project_vertex(vx, vy, vz));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (projections.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input ssp_pkg::t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ssp_pkg::REG_CX: cen_x = value;
            ssp_pkg::REG_CY: cen_y = value;
            ssp_pkg::REG_CZ: cen_z = value;
            default: radius = value[30:0];
        endcase
    endtask

    task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] r);
        write_reg(ssp_pkg::REG_CX, cx);
        write_reg(ssp_pkg::REG_CY, cy);
        write_reg(ssp_pkg::REG_CZ, cz);
        write_reg(ssp_pkg::REG_R, r);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 7) << $urandom_range(0, 28);
            1: return -($urandom_range(1, 255) << 16);
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                       31'h7FFF_FFFF ^ 31'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[4];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        // Vertex exactly at the reset centre gives the top pole.
        send_vertex(0, 0, 0, 0);
        send_vertex(32'h0001_0000, 0, 0, 0);
        send_vertex(0, 32'hFFFF_0000, 0, 0);
        send_vertex(0, 0, 32'h0000_0001, 0);
        for (int i = 0; i < 4; i++)
            send_vertex(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], 0);
        drain_results();
        // Extreme centre and radius: saturating sums and a pole beyond range.
        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000, 32'h7FFF_FFFF);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000, 0);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_vertex(0, 0, 0, 0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0001, 0);
        drain_results();
        // Zero radius collapses everything onto the centre.
        set_sphere(32'h0003_0000, 32'hFFFD_0000, 32'h8000_0000, 0);
        send_vertex(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000, 0);
        send_vertex(32'h0003_0000, 32'hFFFD_0000, 32'h8000_0000, 0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        drain_results();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5)
                set_sphere(0, 0, 0, 32'h0000_8000);
            else
                set_sphere($urandom, $urandom, $urandom, $urandom);
            for (int k = 0; k < 250; k++) begin
                if ($urandom_range(0, 19) == 0)
                    send_vertex(cen_x, cen_y, cen_z, 1);
                else if ($urandom_range(0, 3) == 0)
                    send_vertex(cen_x + rand_coord() % 1024, cen_y - $urandom_range(0, 3),
                                cen_z + $urandom_range(0, 1), 1);
                else
                    send_vertex(rand_coord(), rand_coord(), rand_coord(), 1);
            end
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        // Receiver stops long enough for the pipeline to fill and stall input.
        hold_cycles = 150;
        for (int k = 0; k < 200; k++) send_vertex($urandom, $urandom, $urandom, 0);
        stall_on = 1'b0;
        for (int k = 0; k < 150; k++) send_vertex($urandom, $urandom, $urandom, 0);
        stall_on = 1'b1;
        drain_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_settings();
        test_backpressure();
        drain_results();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
